// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Opcodes, status codes, the record that moves along the cell chain and the
// 32-bit clamp shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MAG = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam int QBITS = 33;

  typedef struct packed {
    logic [2:0]       op;
    logic [31:0]      sre;
    logic [31:0]      sim;
    logic             ssat;
    logic             dz;
    logic             neg_re;
    logic             neg_im;
    logic             over_re;
    logic             over_im;
    logic [63:0]      den;
    logic [63:0]      r_re;
    logic [63:0]      r_im;
    logic [QBITS-1:0] dl_re;
    logic [QBITS-1:0] dl_im;
    logic [QBITS-1:0] q_re;
    logic [QBITS-1:0] q_im;
    logic [63:0]      s;
    logic [35:0]      rem;
    logic [31:0]      root;
  } cell_t;

  // {saturated, clamped value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > 66'sd2147483647) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// Operand register, product stage and sum stage: finishes add, subtract and
// multiply and prepares the dividend, divisor and radicand for the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  in_valid,
  input  wire  [2:0]           opcode,
  input  wire  signed [31:0]   lhs_real,
  input  wire  signed [31:0]   lhs_imag,
  input  wire  signed [31:0]   rhs_real,
  input  wire  signed [31:0]   rhs_imag,
  output logic                 vld,
  output cau_pkg::cell_t       data
);

  localparam int DW = 64 + FRAC_BITS;

  logic               a_valid;
  logic [2:0]         a_op;
  logic signed [31:0] a_a, a_b, a_c, a_d;

  logic               b_valid;
  logic [2:0]         b_op;
  logic [31:0]        b_a, b_b;
  logic [32:0]        b_as;
  logic               b_dz;
  logic signed [63:0] p_ac, p_bd, p_bc, p_ad, p_aa, p_bb, p_cc, p_dd;

  logic signed [32:0] as_re, as_im;
  logic [32:0]        as_sre, as_sim;

  logic signed [65:0] t_re, t_im;
  logic [32:0]        m_re, m_im;
  logic signed [64:0] n_re, n_im;
  logic [63:0]        mag_re, mag_im, den, r0_re, r0_im;
  logic [DW-1:0]      dd_re, dd_im;

  // add and subtract
  always_comb begin
    if (a_op == cau_pkg::OP_SUB) begin
      as_re = {a_a[31], a_a} - {a_c[31], a_c};
      as_im = {a_b[31], a_b} - {a_d[31], a_d};
    end else begin
      as_re = {a_a[31], a_a} + {a_c[31], a_c};
      as_im = {a_b[31], a_b} + {a_d[31], a_d};
    end
    as_sre = cau_pkg::sat32({{33{as_re[32]}}, as_re});
    as_sim = cau_pkg::sat32({{33{as_im[32]}}, as_im});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      vld     <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      vld     <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op <= opcode;
      a_a  <= lhs_real;
      a_b  <= lhs_imag;
      a_c  <= rhs_real;
      a_d  <= rhs_imag;
      b_op <= a_op;
      b_a  <= a_a;
      b_b  <= a_b;
      b_dz <= (a_c == 32'sd0) && (a_d == 32'sd0);
      b_as <= {as_sre[32] | as_sim[32], as_sre[31:0]};
      p_ac <= a_a * a_c;
      p_bd <= a_b * a_d;
      p_bc <= a_b * a_c;
      p_ad <= a_a * a_d;
      p_aa <= a_a * a_a;
      p_bb <= a_b * a_b;
      p_cc <= a_c * a_c;
      p_dd <= a_d * a_d;
    end
  end

  logic [31:0] b_asim;
  always_ff @(posedge clk) begin
    if (en) begin
      b_asim <= as_sim[31:0];
    end
  end

  always_comb begin
    t_re   = {{2{p_ac[63]}}, p_ac} - {{2{p_bd[63]}}, p_bd};
    t_im   = {{2{p_bc[63]}}, p_bc} + {{2{p_ad[63]}}, p_ad};
    m_re   = cau_pkg::sat32(t_re >>> FRAC_BITS);
    m_im   = cau_pkg::sat32(t_im >>> FRAC_BITS);
    n_re   = {p_ac[63], p_ac} + {p_bd[63], p_bd};
    n_im   = {p_bc[63], p_bc} - {p_ad[63], p_ad};
    mag_re = n_re[64] ? 64'(-n_re) : n_re[63:0];
    mag_im = n_im[64] ? 64'(-n_im) : n_im[63:0];
    den    = 64'(p_cc) + 64'(p_dd);
    dd_re  = {mag_re, {FRAC_BITS{1'b0}}};
    dd_im  = {mag_im, {FRAC_BITS{1'b0}}};
    r0_re  = 64'(dd_re >> cau_pkg::QBITS);
    r0_im  = 64'(dd_im >> cau_pkg::QBITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data.op <= b_op;
      case (b_op)
        cau_pkg::OP_MUL: begin
          data.sre  <= m_re[31:0];
          data.sim  <= m_im[31:0];
          data.ssat <= m_re[32] | m_im[32];
        end
        cau_pkg::OP_DIV: begin
          data.sre  <= b_a;
          data.sim  <= b_b;
          data.ssat <= 1'b0;
        end
        default: begin
          data.sre  <= b_as[31:0];
          data.sim  <= b_asim;
          data.ssat <= b_as[32];
        end
      endcase
      data.dz      <= b_dz;
      data.neg_re  <= n_re[64];
      data.neg_im  <= n_im[64];
      data.over_re <= r0_re >= den;
      data.over_im <= r0_im >= den;
      data.den     <= den;
      data.r_re    <= r0_re;
      data.r_im    <= r0_im;
      data.dl_re   <= dd_re[cau_pkg::QBITS-1:0];
      data.dl_im   <= dd_im[cau_pkg::QBITS-1:0];
      data.q_re    <= '0;
      data.q_im    <= '0;
      data.s       <= 64'(p_aa) + 64'(p_bb);
      data.rem     <= '0;
      data.root    <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cau_cell.sv -----
// ----------------------------------------------------------------------------
// cau_cell
// One step of the chain: one restoring divide step for each part and,
// where enabled, one two-bit step of the integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_cell #(
  parameter bit DO_SQRT = 1'b1
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  vld_i,
  input  cau_pkg::cell_t       d_i,
  output logic                 vld_o,
  output cau_pkg::cell_t       d_o
);

  logic [64:0]    r2_re, r2_im, dn, x_re, x_im;
  logic           ge_re, ge_im, ge_sq;
  logic [35:0]    rem2, trial, nrem;
  cau_pkg::cell_t nx;

  always_comb begin
    nx    = d_i;
    dn    = {1'b0, d_i.den};
    r2_re = {d_i.r_re, d_i.dl_re[cau_pkg::QBITS-1]};
    r2_im = {d_i.r_im, d_i.dl_im[cau_pkg::QBITS-1]};
    ge_re = r2_re >= dn;
    ge_im = r2_im >= dn;
    x_re  = ge_re ? r2_re - dn : r2_re;
    x_im  = ge_im ? r2_im - dn : r2_im;
    nx.r_re  = x_re[63:0];
    nx.r_im  = x_im[63:0];
    nx.q_re  = {d_i.q_re[cau_pkg::QBITS-2:0], ge_re};
    nx.q_im  = {d_i.q_im[cau_pkg::QBITS-2:0], ge_im};
    nx.dl_re = {d_i.dl_re[cau_pkg::QBITS-2:0], 1'b0};
    nx.dl_im = {d_i.dl_im[cau_pkg::QBITS-2:0], 1'b0};

    rem2  = {d_i.rem[33:0], d_i.s[63:62]};
    trial = {2'b00, d_i.root, 2'b01};
    ge_sq = rem2 >= trial;
    nrem  = ge_sq ? rem2 - trial : rem2;
    if (DO_SQRT) begin
      nx.rem  = nrem;
      nx.root = {d_i.root[30:0], ge_sq};
      nx.s    = {d_i.s[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= nx;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and magnitude on signed fixed point
// operands with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries opcode and the two operands;
//   output channel out_valid/out_ready carries result_real, result_imag
//   and status (ok, divide by zero, saturated).
//   every item passes an operand register, a product stage, a sum stage,
//   a chain of 33 cells and the output register. each cell does one
//   quotient bit of both divide parts and, all but the first, two radicand
//   bits of the square root, so the chain length sets the latency.
//   one item is accepted per cycle, back to back, unless the output stalls.
//   reset clears all valid flags; no item is in flight afterwards.
//   when the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes and in_ready drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [2:0]         opcode,
  input  wire  signed [31:0] lhs_real,
  input  wire  signed [31:0] lhs_imag,
  input  wire  signed [31:0] rhs_real,
  input  wire  signed [31:0] rhs_imag,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] result_real,
  output logic signed [31:0] result_imag,
  output logic [1:0]         status
);

  localparam int NCELL = cau_pkg::QBITS;

  logic           en;
  logic           vld   [0:NCELL];
  cau_pkg::cell_t chain [0:NCELL];

  cau_pkg::cell_t  last;
  logic [31:0]     re_next, im_next, dre, dim;
  logic [1:0]      status_next;
  logic            sat_re, sat_im;
  logic [NCELL-1:0] lim_re, lim_im;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  cau_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .opcode   (opcode),
    .lhs_real (lhs_real),
    .lhs_imag (lhs_imag),
    .rhs_real (rhs_real),
    .rhs_imag (rhs_imag),
    .vld      (vld[0]),
    .data     (chain[0])
  );

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    cau_cell #(
      .DO_SQRT (j != 0)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vld_i (vld[j]),
      .d_i   (chain[j]),
      .vld_o (vld[j+1]),
      .d_o   (chain[j+1])
    );
  end

  always_comb begin
    last   = chain[NCELL];
    lim_re = last.neg_re ? NCELL'(33'h0_8000_0000) : NCELL'(33'h0_7fff_ffff);
    lim_im = last.neg_im ? NCELL'(33'h0_8000_0000) : NCELL'(33'h0_7fff_ffff);
    sat_re = last.over_re || (last.q_re > lim_re);
    sat_im = last.over_im || (last.q_im > lim_im);
    if (sat_re) begin
      dre = last.neg_re ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      dre = last.neg_re ? 32'(-last.q_re) : last.q_re[31:0];
    end
    if (sat_im) begin
      dim = last.neg_im ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      dim = last.neg_im ? 32'(-last.q_im) : last.q_im[31:0];
    end

    case (last.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        re_next     = last.sre;
        im_next     = last.sim;
        status_next = last.ssat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_DIV: begin
        if (last.dz) begin
          re_next     = last.sre;
          im_next     = last.sim;
          status_next = cau_pkg::ST_DZ;
        end else begin
          re_next     = dre;
          im_next     = dim;
          status_next = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::OP_MAG: begin
        re_next     = last.root[31] ? 32'h7fff_ffff : last.root;
        im_next     = '0;
        status_next = last.root[31] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      default: begin
        re_next     = '0;
        im_next     = '0;
        status_next = cau_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_real <= re_next;
      result_imag <= im_next;
      status      <= status_next;
    end
  end

endmodule

`default_nettype wire

// ----- sim/complex_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Self-checking bench for the complex arithmetic unit. A queue of operand
// items feeds a valid/ready driver with random idle bursts; a monitor with
// random stalls compares every result against an exact software predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LIMIT = 20000;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a, b, c, d;
  } operands_t;

  typedef struct {
    logic [31:0] re, im;
    logic [1:0]  st;
  } answer_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  logic [2:0] opcode = '0;
  logic signed [31:0] lhs_real = '0, lhs_imag = '0, rhs_real = '0, rhs_imag = '0;
  logic signed [31:0] result_real, result_imag;
  logic [1:0] status;

  operands_t pending[$];
  answer_t   awaited[$];
  int errors = 0, idle_cycles = 0, sent = 0, got = 0;
  int send_gap = 0, recv_gap = 0;
  bit calm = 1'b0, hold_send = 1'b0;

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp(input logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // truncating divide, magnitude capped at 2^40
  function automatic logic signed [127:0] qdiv(input logic signed [127:0] n,
                                               input logic signed [127:0] den);
    logic [127:0] m;
    logic [127:0] q;
    m = (n < 0) ? -n : n;
    q = (m << FRAC) / den;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (n < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic answer_t complex_result(input operands_t x);
    answer_t r;
    bit sat;
    logic signed [127:0] a, b, c, d, den, s, root;
    sat = 1'b0;
    a = $signed(x.a); b = $signed(x.b); c = $signed(x.c); d = $signed(x.d);
    r.re = '0; r.im = '0; r.st = cau_pkg::ST_OK;
    case (x.op)
      cau_pkg::OP_ADD: begin
        r.re = clamp(a + c, sat); r.im = clamp(b + d, sat);
      end
      cau_pkg::OP_SUB: begin
        r.re = clamp(a - c, sat); r.im = clamp(b - d, sat);
      end
      cau_pkg::OP_MUL: begin
        r.re = clamp((a * c - b * d) >>> FRAC, sat);
        r.im = clamp((b * c + a * d) >>> FRAC, sat);
      end
      cau_pkg::OP_DIV: begin
        if (c == 0 && d == 0) begin
          r.re = x.a; r.im = x.b; r.st = cau_pkg::ST_DZ;
        end else begin
          den = c * c + d * d;
          r.re = clamp(qdiv(a * c + b * d, den), sat);
          r.im = clamp(qdiv(b * c - a * d, den), sat);
        end
      end
      cau_pkg::OP_MAG: begin
        s = a * a + b * b;
        root = 0;
        for (int i = 32; i >= 0; i--) begin
          if ((root + (128'sd1 <<< i)) * (root + (128'sd1 <<< i)) <= s)
            root = root + (128'sd1 <<< i);
        end
        r.re = clamp(root, sat);
      end
      default: ;
    endcase
    if (sat) r.st = cau_pkg::ST_SAT;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'hffffffff : 32'h1;
      4, 5: return $signed($urandom_range(0, 20'hfffff)) - 32'sh80000;
      6: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(input logic [2:0] op, input logic [31:0] a, b, c, d);
    operands_t x;
    x.op = op; x.a = a; x.b = b; x.c = c; x.d = d;
    pending.push_back(x);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        awaited.push_back(complex_result(
          operands_t'{opcode, lhs_real, lhs_imag, rhs_real, rhs_imag}));
        sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0 && !hold_send) begin
          operands_t x;
          x = pending.pop_front();
          in_valid <= 1'b1;
          opcode <= x.op; lhs_real <= x.a; lhs_imag <= x.b;
          rhs_real <= x.c; rhs_imag <= x.d;
          if (!calm && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got++;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h st=%0d", $time,
                   result_real, result_imag, status);
          errors++;
        end else begin
          answer_t e;
          e = awaited.pop_front();
          if (e.re !== result_real || e.im !== result_imag || e.st !== status) begin
            $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                     $time, e.re, e.im, e.st, result_real, result_imag, status);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    for (int op = 0; op <= 7; op++)
      queue_item(op[2:0], ext[op % 4], ext[(op + 1) % 4], ext[(op + 2) % 4], ext[op % 4]);
    queue_item(cau_pkg::OP_DIV, 32'h00030000, 32'hfffe0000, 32'h0, 32'h0);
    queue_item(cau_pkg::OP_DIV, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h0);
    queue_item(cau_pkg::OP_DIV, 32'h00010000, 32'h00020000, 32'h00030000, 32'hfffc0000);
    queue_item(cau_pkg::OP_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    queue_item(cau_pkg::OP_MAG, 32'h00030000, 32'h00040000, 32'h0, 32'h0);
    queue_item(cau_pkg::OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    queue_item(cau_pkg::OP_MUL, 32'hffffffff, 32'h1, 32'h1, 32'hffffffff);
    queue_item(cau_pkg::OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
    queue_item(cau_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 750; i++) begin
      logic [31:0] c, d;
      c = pick_value(); d = pick_value();
      if ($urandom_range(0, 19) == 0) begin c = '0; d = '0; end
      queue_item($urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7)) :
                 3'($urandom_range(0, 4)), pick_value(), pick_value(), c, d);
      if (i == 300) begin
        wait (pending.size() == 0 && !in_valid);
        hold_send = 1'b1;
        wait (awaited.size() == 0);
        hold_send = 1'b0;
      end
    end
    wait (pending.size() <= 100);
    calm = 1'b1;
    wait (pending.size() == 0 && !in_valid && awaited.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d items over all opcodes, extremes, divide by zero", sent);
    $display("and saturation, with random idling on both sides; %0d results", got);
    if (errors == 0 && awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_tb.sv
